>>> design/tals_pkg.sv
`default_nettype none

package tals_pkg;

  // Width of the solve datapath. Every intermediate of the fit stays well
  // inside this signed range for up to 256 points of 16-bit coordinates.
  localparam int unsigned DW = 128;
  // Multiplier digit width and number of digit steps per product.
  localparam int unsigned DIG_W = 8;
  localparam int unsigned MUL_DIGITS = DW / DIG_W;
  // num * 131072 + q, the doubled scale for the rounding half.
  localparam int unsigned FRAC_SH = 17;
  localparam int unsigned CYC_W = $clog2(DW);
  localparam int unsigned PC_W = 6;
  localparam int unsigned NTMP = 8;
  localparam int unsigned TMP_W = $clog2(NTMP);
  localparam int unsigned NCOEF = 6;
  localparam int unsigned CIDX_W = 3;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SINGULAR = 2'd1,
    STAT_OVERFLOW = 2'd2,
    STAT_TOO_MANY = 2'd3
  } fit_status_e;

  typedef enum logic [4:0] {
    OP_SX, OP_SY, OP_SXY, OP_SX2, OP_SY2, OP_S, OP_SM, OP_SN,
    OP_SMX, OP_SMY, OP_SNX, OP_SNY,
    OP_T1, OP_T2, OP_T3, OP_T4, OP_T5, OP_T6, OP_Q, OP_NUM
  } opnd_e;

  typedef enum logic [1:0] {
    K_TERM, K_QCHK, K_DIV, K_END
  } step_kind_e;

  typedef enum logic [1:0] {
    FIN_NONE, FIN_OVER, FIN_SING, FIN_FIT
  } fin_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_DECODE, ST_FETCH, ST_MLOAD, ST_MUL, ST_ACC,
    ST_DIVLD, ST_DIVABS, ST_DIV, ST_DIVWR, ST_OUT
  } state_e;

  typedef struct packed {
    logic [15:0] device_x;
    logic [15:0] device_y;
    logic [15:0] screen_x;
    logic [15:0] screen_y;
    logic        last_point;
  } in_t;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] coef_e;
    logic signed [31:0] coef_f;
    logic [1:0]         fit_status;
  } out_t;

  typedef struct packed {
    step_kind_e          kind;
    logic                first;
    logic                last;
    logic                neg;
    opnd_e               a;
    opnd_e               b;
    opnd_e               dst;
    logic [CIDX_W-1:0]   cidx;
  } step_t;

  typedef struct packed {
    logic  sample;
    logic  start_fit;
    logic  fetch;
    logic  mul_load;
    logic  mul_step;
    logic  acc_upd;
    logic  div_load;
    logic  div_abs;
    logic  div_step;
    logic  div_write;
    fin_e  fin;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic over;
    logic q_zero;
  } sts_t;

  localparam logic [PC_W-1:0] PC_LAST = 6'd40;

  function automatic step_t term(input logic first, input logic last, input logic neg,
                                 input opnd_e a, input opnd_e b, input opnd_e dst);
    step_t s;
    s.kind  = K_TERM;
    s.first = first;
    s.last  = last;
    s.neg   = neg;
    s.a     = a;
    s.b     = b;
    s.dst   = dst;
    s.cidx  = '0;
    return s;
  endfunction

  function automatic step_t special(input step_kind_e kind, input logic [CIDX_W-1:0] cidx);
    step_t s;
    s.kind  = kind;
    s.first = 1'b0;
    s.last  = 1'b0;
    s.neg   = 1'b0;
    s.a     = OP_NUM;
    s.b     = OP_Q;
    s.dst   = OP_NUM;
    s.cidx  = cidx;
    return s;
  endfunction

  // Solve sequence: cofactors, determinant, a zero check on it, then three terms and a
  // division per coefficient.
  function automatic step_t prog_step(input logic [PC_W-1:0] pc);
    step_t s;
    case (pc)
      6'd0:  s = term(1'b1, 1'b0, 1'b0, OP_SXY, OP_SY,  OP_T1);
      6'd1:  s = term(1'b0, 1'b1, 1'b1, OP_SX,  OP_SY2, OP_T1);
      6'd2:  s = term(1'b1, 1'b0, 1'b0, OP_SXY, OP_SX,  OP_T2);
      6'd3:  s = term(1'b0, 1'b1, 1'b1, OP_SX2, OP_SY,  OP_T2);
      6'd4:  s = term(1'b1, 1'b0, 1'b0, OP_SX2, OP_SY2, OP_T3);
      6'd5:  s = term(1'b0, 1'b1, 1'b1, OP_SXY, OP_SXY, OP_T3);
      6'd6:  s = term(1'b1, 1'b0, 1'b0, OP_SY2, OP_S,   OP_T4);
      6'd7:  s = term(1'b0, 1'b1, 1'b1, OP_SY,  OP_SY,  OP_T4);
      6'd8:  s = term(1'b1, 1'b0, 1'b0, OP_SX,  OP_SY,  OP_T5);
      6'd9:  s = term(1'b0, 1'b1, 1'b1, OP_SXY, OP_S,   OP_T5);
      6'd10: s = term(1'b1, 1'b0, 1'b0, OP_SX2, OP_S,   OP_T6);
      6'd11: s = term(1'b0, 1'b1, 1'b1, OP_SX,  OP_SX,  OP_T6);
      6'd12: s = term(1'b1, 1'b0, 1'b0, OP_T1,  OP_SX,  OP_Q);
      6'd13: s = term(1'b0, 1'b0, 1'b0, OP_T2,  OP_SY,  OP_Q);
      6'd14: s = term(1'b0, 1'b1, 1'b0, OP_T3,  OP_S,   OP_Q);
      6'd15: s = special(K_QCHK, 3'd0);
      6'd16: s = term(1'b1, 1'b0, 1'b0, OP_T4,  OP_SMX, OP_NUM);
      6'd17: s = term(1'b0, 1'b0, 1'b0, OP_T5,  OP_SMY, OP_NUM);
      6'd18: s = term(1'b0, 1'b1, 1'b0, OP_T1,  OP_SM,  OP_NUM);
      6'd19: s = special(K_DIV, 3'd0);
      6'd20: s = term(1'b1, 1'b0, 1'b0, OP_T5,  OP_SMX, OP_NUM);
      6'd21: s = term(1'b0, 1'b0, 1'b0, OP_T6,  OP_SMY, OP_NUM);
      6'd22: s = term(1'b0, 1'b1, 1'b0, OP_T2,  OP_SM,  OP_NUM);
      6'd23: s = special(K_DIV, 3'd1);
      6'd24: s = term(1'b1, 1'b0, 1'b0, OP_T1,  OP_SMX, OP_NUM);
      6'd25: s = term(1'b0, 1'b0, 1'b0, OP_T2,  OP_SMY, OP_NUM);
      6'd26: s = term(1'b0, 1'b1, 1'b0, OP_T3,  OP_SM,  OP_NUM);
      6'd27: s = special(K_DIV, 3'd2);
      6'd28: s = term(1'b1, 1'b0, 1'b0, OP_T4,  OP_SNX, OP_NUM);
      6'd29: s = term(1'b0, 1'b0, 1'b0, OP_T5,  OP_SNY, OP_NUM);
      6'd30: s = term(1'b0, 1'b1, 1'b0, OP_T1,  OP_SN,  OP_NUM);
      6'd31: s = special(K_DIV, 3'd3);
      6'd32: s = term(1'b1, 1'b0, 1'b0, OP_T5,  OP_SNX, OP_NUM);
      6'd33: s = term(1'b0, 1'b0, 1'b0, OP_T6,  OP_SNY, OP_NUM);
      6'd34: s = term(1'b0, 1'b1, 1'b0, OP_T2,  OP_SN,  OP_NUM);
      6'd35: s = special(K_DIV, 3'd4);
      6'd36: s = term(1'b1, 1'b0, 1'b0, OP_T1,  OP_SNX, OP_NUM);
      6'd37: s = term(1'b0, 1'b0, 1'b0, OP_T2,  OP_SNY, OP_NUM);
      6'd38: s = term(1'b0, 1'b1, 1'b0, OP_T3,  OP_SN,  OP_NUM);
      6'd39: s = special(K_DIV, 3'd5);
      default: s = special(K_END, 3'd0);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> design/touch_affine_least_squares_fit.sv
`default_nettype none

// Channel   Direction  Handshake                Payload
// in        sink       in_valid_i / in_ready_o  in_data_i  (one calibration pair)
// out       source     out_valid_o / out_ready_i out_data_o (six coefficients, status)
//
// A pair that is not the last of its set is folded into the running sums as it
// is taken, so pairs stream at one transaction per cycle while no solve runs.
// The final pair starts the solve: 33 products on a digit-serial multiplier and
// six 128-step restoring divisions, all sequenced over one shared datapath, then
// the result is offered. Too many points or a zero determinant end it early.
// While the result waits to be taken, further pairs of the next set are accepted;
// a final pair is held off until the pending result has gone.
// Reset is asynchronous and clears the sums, the count and the sequencer.
module touch_affine_least_squares_fit #(
  parameter int unsigned MAX_POINTS = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tals_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tals_pkg::out_t     out_data_o
);
  import tals_pkg::*;

  // The sequencer drives every datapath step; the datapath answers with two
  // status bits (too many points, zero determinant).
  cmd_t cmd;
  sts_t sts;

  tals_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_point),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tals_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // A transaction on the input during a pending result never carries the
  // final pair, so the held result cannot be overwritten.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_valid_i && in_ready_o |-> !in_data_i.last_point)
    else $error("final pair taken while a result was pending");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o.fit_status))
    else $error("pending result status changed");

  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.fit_status != STAT_OK) |-> (out_data_o.coef_a == '0))
    else $error("failed fit reported with nonzero coefficients");

endmodule

`default_nettype wire

>>> design/tals_ctrl.sv
`default_nettype none

module tals_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire tals_pkg::sts_t sts_i,
  output tals_pkg::cmd_t     cmd_o
);
  import tals_pkg::*;

  state_e           state_q, state_d;
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [CYC_W-1:0] cnt_q, cnt_d;
  step_t            step;
  logic             in_acc;

  assign step   = prog_step(pc_q);
  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_last_i) state_d = ST_START;
      end
      ST_START: begin
        pc_d    = '0;
        state_d = sts_i.over ? ST_OUT : ST_DECODE;
      end
      ST_DECODE: begin
        case (step.kind)
          K_TERM, K_DIV: state_d = ST_FETCH;
          K_QCHK: begin
            if (sts_i.q_zero) begin
              state_d = ST_OUT;
            end else begin
              pc_d = pc_q + 1'b1;
            end
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_FETCH: state_d = (step.kind == K_TERM) ? ST_MLOAD : ST_DIVLD;
      ST_MLOAD: begin
        cnt_d   = CYC_W'(MUL_DIGITS - 1);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_q == '0) state_d = ST_ACC;
        else cnt_d = cnt_q - 1'b1;
      end
      ST_ACC: begin
        pc_d    = pc_q + 1'b1;
        state_d = ST_DECODE;
      end
      ST_DIVLD: state_d = ST_DIVABS;
      ST_DIVABS: begin
        cnt_d   = CYC_W'(DW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_DIVWR;
        else cnt_d = cnt_q - 1'b1;
      end
      ST_DIVWR: begin
        pc_d    = pc_q + 1'b1;
        state_d = ST_DECODE;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_OUT) && !in_last_i);
    out_valid_o = (state_q == ST_OUT);
    cmd_o           = '0;
    cmd_o.step      = step;
    cmd_o.fin       = FIN_NONE;
    cmd_o.sample    = in_acc;
    cmd_o.start_fit = (state_q == ST_START);
    cmd_o.fetch     = (state_q == ST_FETCH);
    cmd_o.mul_load  = (state_q == ST_MLOAD);
    cmd_o.mul_step  = (state_q == ST_MUL);
    cmd_o.acc_upd   = (state_q == ST_ACC);
    cmd_o.div_load  = (state_q == ST_DIVLD);
    cmd_o.div_abs   = (state_q == ST_DIVABS);
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.div_write = (state_q == ST_DIVWR);
    case (state_q)
      ST_START: begin
        if (sts_i.over) cmd_o.fin = FIN_OVER;
      end
      ST_DECODE: begin
        if ((step.kind == K_QCHK) && sts_i.q_zero) cmd_o.fin = FIN_SING;
        else if (step.kind == K_END) cmd_o.fin = FIN_FIT;
      end
      default: cmd_o.fin = FIN_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
    end
  end

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && (cnt_q == '0) |=> (state_q == ST_DIVWR))
    else $error("division did not finish after its last step");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && in_acc && in_last_i |=> (state_q == ST_START))
    else $error("final pair did not start the solve");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) && (state_q != ST_START) |-> (pc_q <= PC_LAST))
    else $error("sequence counter ran past the end of the solve");

  a_no_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sample |-> ((state_q == ST_IDLE) || (state_q == ST_OUT)))
    else $error("pair taken while the solve is running");

endmodule

`default_nettype wire

>>> design/tals_dp.sv
`default_nettype none

module tals_dp #(
  parameter int unsigned MAX_POINTS = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tals_pkg::cmd_t cmd_i,
  input  wire tals_pkg::in_t  in_data_i,
  output tals_pkg::sts_t      sts_o,
  output tals_pkg::out_t      out_data_o
);
  import tals_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 2);
  localparam int unsigned SUM_W = COORD_BITS + $clog2(MAX_POINTS + 1);
  localparam int unsigned PRD_W = 2 * COORD_BITS + $clog2(MAX_POINTS + 1);
  localparam int unsigned PW    = 2 * COORD_BITS;

  typedef struct packed {
    logic [DW-1:0] sx, sy, sxy, sx2, sy2, s, sm, sn, smx, smy, snx, sny;
  } sums_t;

  function automatic logic [DW-1:0] pick(input sums_t v, input opnd_e k);
    logic [DW-1:0] r;
    case (k)
      OP_SX:   r = v.sx;
      OP_SY:   r = v.sy;
      OP_SXY:  r = v.sxy;
      OP_SX2:  r = v.sx2;
      OP_SY2:  r = v.sy2;
      OP_S:    r = v.s;
      OP_SM:   r = v.sm;
      OP_SN:   r = v.sn;
      OP_SMX:  r = v.smx;
      OP_SMY:  r = v.smy;
      OP_SNX:  r = v.snx;
      OP_SNY:  r = v.sny;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [TMP_W-1:0] tidx(input opnd_e k);
    return TMP_W'(int'(k) - int'(OP_T1));
  endfunction

  // Running sums
  logic [SUM_W-1:0] sum_dx_q, sum_dy_q, sum_sx_q, sum_sy_q;
  logic [PRD_W-1:0] sum_dx_dy_q, sum_dx_sq_q, sum_dy_sq_q;
  logic [PRD_W-1:0] sum_sx_dx_q, sum_sx_dy_q, sum_sy_dx_q, sum_sy_dy_q;
  logic [CNT_W-1:0] point_count_q;

  logic [COORD_BITS-1:0] x, y, m, n;
  logic                  room;
  logic                  clear;

  assign x     = in_data_i.device_x[COORD_BITS-1:0];
  assign y     = in_data_i.device_y[COORD_BITS-1:0];
  assign m     = in_data_i.screen_x[COORD_BITS-1:0];
  assign n     = in_data_i.screen_y[COORD_BITS-1:0];
  assign room  = point_count_q < CNT_W'(MAX_POINTS);
  assign clear = (cmd_i.fin != FIN_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_dx_q <= '0; sum_dy_q <= '0; sum_sx_q <= '0; sum_sy_q <= '0;
      sum_dx_dy_q <= '0; sum_dx_sq_q <= '0; sum_dy_sq_q <= '0;
      sum_sx_dx_q <= '0; sum_sx_dy_q <= '0; sum_sy_dx_q <= '0; sum_sy_dy_q <= '0;
      point_count_q <= '0;
    end else if (clear) begin
      sum_dx_q <= '0; sum_dy_q <= '0; sum_sx_q <= '0; sum_sy_q <= '0;
      sum_dx_dy_q <= '0; sum_dx_sq_q <= '0; sum_dy_sq_q <= '0;
      sum_sx_dx_q <= '0; sum_sx_dy_q <= '0; sum_sy_dx_q <= '0; sum_sy_dy_q <= '0;
      point_count_q <= '0;
    end else if (cmd_i.sample) begin
      if (room) begin
        sum_dx_q    <= sum_dx_q + SUM_W'(x);
        sum_dy_q    <= sum_dy_q + SUM_W'(y);
        sum_sx_q    <= sum_sx_q + SUM_W'(m);
        sum_sy_q    <= sum_sy_q + SUM_W'(n);
        sum_dx_dy_q <= sum_dx_dy_q + PRD_W'(PW'(x) * PW'(y));
        sum_dx_sq_q <= sum_dx_sq_q + PRD_W'(PW'(x) * PW'(x));
        sum_dy_sq_q <= sum_dy_sq_q + PRD_W'(PW'(y) * PW'(y));
        sum_sx_dx_q <= sum_sx_dx_q + PRD_W'(PW'(m) * PW'(x));
        sum_sx_dy_q <= sum_sx_dy_q + PRD_W'(PW'(m) * PW'(y));
        sum_sy_dx_q <= sum_sy_dx_q + PRD_W'(PW'(n) * PW'(x));
        sum_sy_dy_q <= sum_sy_dy_q + PRD_W'(PW'(n) * PW'(y));
        point_count_q <= point_count_q + 1'b1;
      end else begin
        point_count_q <= CNT_W'(MAX_POINTS + 1);
      end
    end
  end

  sums_t sums;
  always_comb begin
    sums.sx  = DW'(sum_dx_q);
    sums.sy  = DW'(sum_dy_q);
    sums.sxy = DW'(sum_dx_dy_q);
    sums.sx2 = DW'(sum_dx_sq_q);
    sums.sy2 = DW'(sum_dy_sq_q);
    sums.s   = DW'(point_count_q);
    sums.sm  = DW'(sum_sx_q);
    sums.sn  = DW'(sum_sy_q);
    sums.smx = DW'(sum_sx_dx_q);
    sums.smy = DW'(sum_sx_dy_q);
    sums.snx = DW'(sum_sy_dx_q);
    sums.sny = DW'(sum_sy_dy_q);
  end

  // Operand fetch from sums or the scratch store
  logic [DW-1:0] tmp_mem [NTMP];
  logic [DW-1:0] op_a_q, op_b_q;
  logic [DW-1:0] acc_q, acc_d;
  logic [DW-1:0] prod_q, mag_a_q, mag_b_q;
  logic          msign_q;

  assign acc_d = (cmd_i.step.first ? '0 : acc_q) + (prod_q ^ {DW{msign_q}}) + DW'(msign_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      op_a_q <= (cmd_i.step.a >= OP_T1) ? tmp_mem[tidx(cmd_i.step.a)] : pick(sums, cmd_i.step.a);
      op_b_q <= (cmd_i.step.b >= OP_T1) ? tmp_mem[tidx(cmd_i.step.b)] : pick(sums, cmd_i.step.b);
    end
    if (cmd_i.acc_upd && cmd_i.step.last) begin
      tmp_mem[tidx(cmd_i.step.dst)] <= acc_d;
    end
  end

  // Digit-serial signed multiply-accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      mag_a_q <= mag(op_a_q);
      mag_b_q <= mag(op_b_q);
      msign_q <= op_a_q[DW-1] ^ op_b_q[DW-1] ^ cmd_i.step.neg;
      prod_q  <= '0;
    end else if (cmd_i.mul_step) begin
      prod_q  <= prod_q + mag_a_q * mag_b_q[DIG_W-1:0];
      mag_a_q <= mag_a_q << DIG_W;
      mag_b_q <= mag_b_q >> DIG_W;
    end
    if (cmd_i.acc_upd) acc_q <= acc_d;
  end

  // Restoring divider for (num*2^17 + q) / 2q
  logic [DW-1:0] dn_q, dd_q, rem_q, quo_q;
  logic          dneg_q;
  logic [DW:0]   rem_sh, diff;
  logic          ge, big_quo;
  logic [31:0]   cval;

  assign rem_sh  = {rem_q, dn_q[DW-1]};
  assign diff    = rem_sh - {1'b0, dd_q};
  assign ge      = !diff[DW];
  assign big_quo = |quo_q[DW-1:31];
  assign cval    = dneg_q ? (32'd0 - quo_q[31:0]) : quo_q[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dn_q <= (op_a_q << FRAC_SH) + op_b_q;
      dd_q <= op_b_q << 1;
    end else if (cmd_i.div_abs) begin
      dneg_q <= dn_q[DW-1] ^ dd_q[DW-1];
      dn_q   <= mag(dn_q);
      dd_q   <= mag(dd_q);
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
      dn_q  <= dn_q << 1;
    end
  end

  // Result register
  logic [31:0] coef_q [NCOEF];
  logic        ovf_q;
  logic [1:0]  status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else if (cmd_i.start_fit) begin
      ovf_q <= 1'b0;
    end else if (cmd_i.div_write && big_quo) begin
      ovf_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_write) begin
      coef_q[cmd_i.step.cidx] <= big_quo ? 32'd0 : cval;
    end
    case (cmd_i.fin)
      FIN_OVER: begin
        status_q <= STAT_TOO_MANY;
        for (int i = 0; i < NCOEF; i++) coef_q[i] <= '0;
      end
      FIN_SING: begin
        status_q <= STAT_SINGULAR;
        for (int i = 0; i < NCOEF; i++) coef_q[i] <= '0;
      end
      FIN_FIT: begin
        status_q <= ovf_q ? STAT_OVERFLOW : STAT_OK;
        if (ovf_q) begin
          for (int i = 0; i < NCOEF; i++) coef_q[i] <= '0;
        end
      end
      default: status_q <= status_q;
    endcase
  end

  assign sts_o.over   = point_count_q > CNT_W'(MAX_POINTS);
  assign sts_o.q_zero = (acc_q == '0);

  assign out_data_o.coef_a     = coef_q[0];
  assign out_data_o.coef_b     = coef_q[1];
  assign out_data_o.coef_c     = coef_q[2];
  assign out_data_o.coef_d     = coef_q[3];
  assign out_data_o.coef_e     = coef_q[4];
  assign out_data_o.coef_f     = coef_q[5];
  assign out_data_o.fit_status = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_count_q <= CNT_W'(MAX_POINTS + 1))
    else $error("point count beyond its sticky limit");

  a_clear_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (point_count_q == '0) && (sum_dx_q == '0))
    else $error("sums not cleared after a solve");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (rem_q < dd_q))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
